// ===== rtl/mfdp_pkg.sv =====
// shared constants and controller/datapath interface types for the delta prefetcher
package mfdp_pkg;

    localparam int ADDR_W             = 64;
    localparam int HISTORY_DEPTH_DEF  = 16;
    localparam int BLOCK_SHIFT_DEF    = 6;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // take the request, push its line into the history
        logic load;     // build the neighbor difference array, clear the best
        logic step;     // score one candidate delta and rotate the array
        logic emit;     // load the output register with the prefetch
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic hit;          // request on the input is a cache hit
        logic primed_next;  // history is full once this request is pushed
        logic scan_last;    // current step scores the last candidate
        logic out_free;     // output register can take a new prefetch now
    } t_stat;

endpackage

// ===== rtl/mfdp_ctrl.sv =====
// sequencing state machine for the delta prefetcher
module mfdp_ctrl
    import mfdp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.hit) begin
                        n_state = S_IDLE;
                    end else if (i_stat.primed_next) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    // a hit request never produces work after it
    a_hit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.hit) |=> (r_state == S_IDLE))
        else $error("hit request did not return to idle");

    // a scan is always preceded by a load or another scan step
    a_scan_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SCAN) |-> $past(r_state == S_LOAD))
        else $error("scan entered without load");

    // only one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command issued");
`endif

endmodule

// ===== rtl/mfdp_dpath.sv =====
// line history, delta scoring and output register of the delta prefetcher
module mfdp_dpath
    import mfdp_pkg::*;
#(
    parameter int HistDepth  = HISTORY_DEPTH_DEF,
    parameter int BlockShift = BLOCK_SHIFT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [ADDR_W-1:0]        i_access_addr,
    input  logic [ADDR_W-1:0]        i_access_ip,
    input  logic                     i_was_hit,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ADDR_W-1:0]        o_prefetch_addr,
    output logic signed [ADDR_W-1:0] o_chosen_delta,
    output logic [ADDR_W-1:0]        o_trigger_ip
);

    localparam int LINE_W = ADDR_W - BlockShift;
    localparam int DIFF_W = (LINE_W < ADDR_W) ? LINE_W + 1 : ADDR_W;
    localparam int NDIFF  = HistDepth - 1;
    localparam int FILL_W = $clog2(HistDepth + 1);
    localparam int CNT_W  = $clog2(HistDepth);
    localparam int SCAN_W = $clog2(HistDepth);

    logic [LINE_W-1:0]        r_hist [HistDepth];
    logic [FILL_W-1:0]        r_fill;
    logic signed [DIFF_W-1:0] r_diff [NDIFF];
    logic signed [DIFF_W-1:0] r_best_diff;
    logic [CNT_W-1:0]         r_best_cnt;
    logic [SCAN_W-1:0]        r_scan;
    logic [ADDR_W-1:0]        r_addr;
    logic [ADDR_W-1:0]        r_ip;
    logic [ADDR_W-1:0]        r_delta;
    logic                     r_out_valid;
    logic [ADDR_W-1:0]        r_out_addr;
    logic [ADDR_W-1:0]        r_out_delta;
    logic [ADDR_W-1:0]        r_out_ip;

    logic [NDIFF-1:0]         match;
    logic [CNT_W-1:0]         cand_cnt;
    logic                     cand_wins;

    // status toward the controller
    assign o_stat.hit         = i_was_hit;
    assign o_stat.primed_next = (r_fill >= FILL_W'(HistDepth - 1));
    assign o_stat.scan_last   = (r_scan == SCAN_W'(NDIFF - 1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // candidate at the head of the array against every difference
    always_comb begin
        for (int k = 0; k < NDIFF; k++) begin
            match[k] = (r_diff[k] == r_diff[0]);
        end
    end
    assign cand_cnt  = CNT_W'($countones(match));
    assign cand_wins = (cand_cnt > r_best_cnt) ||
                       ((cand_cnt == r_best_cnt) && (r_diff[0] < r_best_diff));

    // line history shift, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int k = 0; k < HistDepth - 1; k++) begin
                r_hist[k] <= r_hist[k+1];
            end
            r_hist[HistDepth-1] <= i_access_addr[ADDR_W-1:BlockShift];
            r_addr              <= i_access_addr;
            r_ip                <= i_access_ip;
        end
    end

    // fill count saturates at the history depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.accept && (r_fill != FILL_W'(HistDepth))) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    // difference array, rotating candidate scan and best tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_delta <= ADDR_W'(1);
        end
        if (i_cmd.load) begin
            for (int k = 0; k < NDIFF; k++) begin
                r_diff[k] <= DIFF_W'(r_hist[k+1]) - DIFF_W'(r_hist[k]);
            end
            r_best_cnt <= '0;
            r_best_diff <= '0;
            r_scan      <= '0;
        end else if (i_cmd.step) begin
            for (int k = 0; k < NDIFF - 1; k++) begin
                r_diff[k] <= r_diff[k+1];
            end
            r_diff[NDIFF-1] <= r_diff[0];
            r_scan          <= r_scan + SCAN_W'(1);
            if (cand_wins) begin
                r_best_cnt  <= cand_cnt;
                r_best_diff <= r_diff[0];
                r_delta     <= ADDR_W'(r_diff[0]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_addr  <= r_addr + (r_delta << BlockShift);
            r_out_delta <= r_delta;
            r_out_ip    <= r_ip;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_prefetch_addr = r_out_addr;
    assign o_chosen_delta  = $signed(r_out_delta);
    assign o_trigger_ip    = r_out_ip;

`ifndef ASSERT_OFF
    // the output register is never overwritten while it still holds a request
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("prefetch overwritten before taken");

    // mode search only runs on a full history
    a_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_fill == FILL_W'(HistDepth)))
        else $error("mode search on partial history");

    // after any scoring step the best delta has been seen at least once
    a_best_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_best_cnt != '0))
        else $error("best count still zero after a step");
`endif

endmodule

// ===== rtl/most_frequent_delta_prefetcher.sv =====
// top level of the most-frequent-delta stride prefetcher
// Each accepted request shifts its line address (addr >> BLOCK_SHIFT) into a
// history of the last HISTORY_DEPTH lines. A hit produces no prefetch and the
// block is ready again in the next cycle. A miss produces one prefetch: delta
// +1 line until the history has filled once, else the most frequent of the
// HISTORY_DEPTH-1 neighbor differences (ties to the smallest signed delta).
// A miss on a partly filled history goes from the accept straight to the emit
// state; a miss on a full history first passes a load state and the serial
// scan that scores one candidate delta per cycle against all differences in
// parallel. A finished prefetch waits in an output register, so the next
// request is taken while it is pending; the block only stalls when a second
// prefetch is ready before the first was taken.
module most_frequent_delta_prefetcher
    import mfdp_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int BLOCK_SHIFT   = BLOCK_SHIFT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [ADDR_W-1:0]        i_access_addr,
    input  logic [ADDR_W-1:0]        i_access_ip,
    input  logic                     i_was_hit,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ADDR_W-1:0]        o_prefetch_addr,
    output logic signed [ADDR_W-1:0] o_chosen_delta,
    output logic [ADDR_W-1:0]        o_trigger_ip
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    mfdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // history, scoring and output register
    mfdp_dpath #(
        .HistDepth  (HISTORY_DEPTH),
        .BlockShift (BLOCK_SHIFT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_access_addr   (i_access_addr),
        .i_access_ip     (i_access_ip),
        .i_was_hit       (i_was_hit),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_prefetch_addr (o_prefetch_addr),
        .o_chosen_delta  (o_chosen_delta),
        .o_trigger_ip    (o_trigger_ip)
    );

endmodule
